@@ rtl/core/bsce_pkg.sv @@
// shared types and constants for the state-of-charge estimator
`default_nettype none
package bsce_pkg;
  localparam int TablePoints = 16;
  localparam int IdxW = $clog2(TablePoints);
  localparam int SocW = 14;
  localparam int AccW = 48;
  localparam int DivW = 48;
  localparam int DivCntW = 6;
  localparam logic [SocW-1:0] SocFull = 14'd10000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_POINT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CAPACITY  = 2'd0,
    CFG_CHG_LIMIT = 2'd1,
    CFG_DSG_LIMIT = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_MUL,
    ST_TICK_ACC,
    ST_TICK_DIV,
    ST_TICK_END,
    ST_SCAN,
    ST_INTERP_MUL,
    ST_INTERP_DIV,
    ST_INTERP_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/bsce_divider.sv @@
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module bsce_divider import bsce_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);
  logic [DivW-1:0]    quo_r, quo_nxt;
  logic [DivW-1:0]    rem_r, rem_nxt;
  logic [DivW-1:0]    dsr_r, dsr_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivW:0]      trial;
  logic [DivW:0]      shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[DivW-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = DivCntW'(DivW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DivW]) begin
        rem_nxt = trial[DivW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DivW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

@@ rtl/core/battery_soc_coulomb_estimator.sv @@
// top level of the coulomb-counting state-of-charge estimator
// tick: multiply, accumulate, check; 48-bit divider runs when |accumulator| > capacity*3600
// reset estimate: scan of up to 16 table points, then multiply and divide for interpolation
// table write and percent reset go straight to the result; one request at a time, no overlap
// a new request is taken only once the previous result has been handed over
// synchronous active-low reset restores register defaults and clears soc, accumulator, tables
`default_nettype none
module battery_soc_coulomb_estimator import bsce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [19:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_command,
  input  wire logic signed [19:0] in_current_ma,
  input  wire logic [15:0]       in_elapsed_ms,
  input  wire logic signed [7:0] in_percent,
  input  wire logic [15:0]       in_cell_voltage_mv,
  input  wire logic [3:0]        in_point_index,
  input  wire logic [15:0]       in_point_voltage_mv,
  input  wire logic [13:0]       in_point_soc,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SocW-1:0]        out_soc,
  output logic                   out_soc_changed
);
  logic [19:0] cap_r;
  logic [15:0] chg_r, dsg_r;
  logic [15:0] ocv_r [TablePoints];
  logic [SocW-1:0] stab_r [TablePoints];
  logic [TablePoints-1:0] ocv_nz_r, soc_nz_r;

  state_t state_r, state_nxt;
  logic [SocW-1:0] level_r, level_nxt;
  logic [SocW-1:0] before_r, before_nxt;
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [35:0] prod_r, prod_nxt;
  logic signed [19:0] cur_r, cur_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [15:0] volt_r, volt_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic use_tab_r, use_tab_nxt;
  logic rising_r, rising_nxt;
  logic neg_r, neg_nxt;
  logic [16:0] lo_a_r, lo_a_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic signed [15:0] db_r, db_nxt;
  logic [SocW-1:0] base_r, base_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [SocW-1:0] out_soc_r, out_soc_nxt;
  logic out_chg_r, out_chg_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  bsce_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [19:0] cap_eff;
  logic [AccW-1:0] acc_mag;
  logic [15:0] a_i, a_p;
  logic [SocW-1:0] b_i, b_p, b_first, b_last;
  logic hit, last;
  logic signed [AccW-1:0] sq;
  logic signed [AccW+1:0] sum_w;
  logic signed [33:0] iprod;
  logic signed [19:0] ires;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign cap_eff  = (cap_r == '0) ? 20'd1 : cap_r;

  always_comb begin
    if (use_tab_r) begin
      a_i = ocv_r[idx_r];
      a_p = ocv_r[idx_r - 1'b1];
      b_i = stab_r[idx_r];
      b_p = stab_r[idx_r - 1'b1];
      b_first = stab_r[0];
      b_last  = stab_r[TablePoints-1];
      last = (idx_r == IdxW'(TablePoints - 1));
    end else begin
      a_i = idx_r[0] ? dsg_r : chg_r;
      a_p = chg_r;
      b_i = idx_r[0] ? '0 : SocFull;
      b_p = SocFull;
      b_first = SocFull;
      b_last  = '0;
      last = idx_r[0];
    end
    hit = rising_r ? (volt_r <= a_i) : (volt_r >= a_i);
  end

  always_comb begin
    state_nxt   = state_r;
    level_nxt   = level_r;
    before_nxt  = before_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    cur_nxt     = cur_r;
    ms_nxt      = ms_r;
    volt_nxt    = volt_r;
    idx_nxt     = idx_r;
    use_tab_nxt = use_tab_r;
    rising_nxt  = rising_r;
    neg_nxt     = neg_r;
    lo_a_nxt    = lo_a_r;
    dvs_nxt     = dvs_r;
    db_nxt      = db_r;
    base_nxt    = base_r;
    out_valid_nxt = out_valid_r;
    out_soc_nxt = out_soc_r;
    out_chg_nxt = out_chg_r;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    acc_mag = acc_r[AccW-1] ? AccW'(-acc_r) : acc_r;
    sq = neg_r ? -$signed(drsp.quotient) : $signed(drsp.quotient);
    sum_w = $signed({2'b00, level_r}) + sq;
    iprod = db_r * $signed(lo_a_r);
    ires  = $signed({6'd0, base_r}) + (neg_r ? -$signed(drsp.quotient[19:0])
                                             : $signed(drsp.quotient[19:0]));
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          before_nxt = level_r;
          cur_nxt  = in_current_ma;
          ms_nxt   = in_elapsed_ms;
          volt_nxt = in_cell_voltage_mv;
          state_nxt = ST_DONE;
          case (cmd_t'(in_command))
            CMD_TICK: state_nxt = ST_TICK_MUL;
            CMD_RESET: begin
              if (in_percent >= 0 && in_percent <= 8'sd100) begin
                level_nxt = SocW'(7'(in_percent) * 14'd100);
              end else if ((|ocv_nz_r) && (|soc_nz_r)) begin
                use_tab_nxt = 1'b1;
                rising_nxt = ocv_r[0] < ocv_r[TablePoints-1];
                idx_nxt = '0;
                state_nxt = ST_SCAN;
              end else if (chg_r == dsg_r) begin
                level_nxt = '0;
              end else begin
                use_tab_nxt = 1'b0;
                rising_nxt = chg_r < dsg_r;
                idx_nxt = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK_MUL: begin
        prod_nxt = cur_r * $signed({1'b0, ms_r});
        state_nxt = ST_TICK_ACC;
      end
      ST_TICK_ACC: begin
        acc_nxt = acc_r + AccW'(prod_r);
        state_nxt = ST_TICK_DIV;
      end
      ST_TICK_DIV: begin
        if (acc_mag > AccW'(cap_eff) * AccW'(3600)) begin
          dreq.start = 1'b1;
          dreq.dividend = acc_mag;
          dreq.divisor = AccW'(cap_eff) * AccW'(360);
          neg_nxt = acc_r[AccW-1];
          state_nxt = ST_TICK_END;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_TICK_END: begin
        if (drsp.done) begin
          if (sum_w < 0) level_nxt = '0;
          else if (sum_w > $signed({2'b00, 34'(SocFull)})) level_nxt = SocFull;
          else level_nxt = sum_w[SocW-1:0];
          acc_nxt = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (idx_r == '0) begin
            level_nxt = (b_first > SocFull) ? SocFull : b_first;
            state_nxt = ST_DONE;
          end else if (a_i == a_p) begin
            level_nxt = (b_i > SocFull) ? SocFull : b_i;
            state_nxt = ST_DONE;
          end else begin
            db_nxt = $signed({2'b00, b_i}) - $signed({2'b00, b_p});
            lo_a_nxt = {1'b0, volt_r} - {1'b0, a_p};
            dvs_nxt = (a_i > a_p) ? a_i - a_p : a_p - a_i;
            neg_nxt = (a_i < a_p);
            base_nxt = b_p;
            state_nxt = ST_INTERP_MUL;
          end
        end else if (last) begin
          level_nxt = (b_last > SocFull) ? SocFull : b_last;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_INTERP_MUL: begin
        prod_nxt = 36'(iprod);
        state_nxt = ST_INTERP_DIV;
      end
      ST_INTERP_DIV: begin
        dreq.start = 1'b1;
        dreq.dividend = prod_r[35] ? AccW'(-prod_r) : AccW'(prod_r);
        dreq.divisor = AccW'(dvs_r);
        neg_nxt = neg_r ^ prod_r[35];
        state_nxt = ST_INTERP_END;
      end
      ST_INTERP_END: begin
        if (drsp.done) begin
          if (ires < 0) level_nxt = '0;
          else if (ires > $signed(20'(SocFull))) level_nxt = SocFull;
          else level_nxt = ires[SocW-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_soc_nxt = level_r;
        out_chg_nxt = (level_r != before_r);
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      level_r <= '0;
      acc_r <= '0;
      cap_r <= 20'd50000;
      chg_r <= 16'd3650;
      dsg_r <= 16'd2500;
      ocv_nz_r <= '0;
      soc_nz_r <= '0;
      for (int i = 0; i < TablePoints; i++) begin
        ocv_r[i] <= '0;
        stab_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      level_r <= level_nxt;
      acc_r <= acc_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CAPACITY:  cap_r <= cfg_data;
          CFG_CHG_LIMIT: chg_r <= cfg_data[15:0];
          CFG_DSG_LIMIT: dsg_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready && cmd_t'(in_command) == CMD_POINT) begin
        ocv_r[in_point_index[IdxW-1:0]] <= in_point_voltage_mv;
        stab_r[in_point_index[IdxW-1:0]] <= in_point_soc;
        ocv_nz_r[in_point_index[IdxW-1:0]] <= (in_point_voltage_mv != '0);
        soc_nz_r[in_point_index[IdxW-1:0]] <= (in_point_soc != '0);
      end
    end
    before_r <= before_nxt;
    prod_r <= prod_nxt;
    cur_r <= cur_nxt;
    ms_r <= ms_nxt;
    volt_r <= volt_nxt;
    idx_r <= idx_nxt;
    use_tab_r <= use_tab_nxt;
    rising_r <= rising_nxt;
    neg_r <= neg_nxt;
    lo_a_r <= lo_a_nxt;
    dvs_r <= dvs_nxt;
    db_r <= db_nxt;
    base_r <= base_nxt;
    out_soc_r <= out_soc_nxt;
    out_chg_r <= out_chg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_soc = out_soc_r;
  assign out_soc_changed = out_chg_r;
endmodule
`default_nettype wire

@@ rtl/core/bsce_checker.sv @@
// port-level checks for the state-of-charge estimator
`default_nettype none
module bsce_checker import bsce_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [SocW-1:0] out_soc,
  input wire logic out_soc_changed
);
  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_soc <= SocFull) else $error("soc out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_soc) && $stable(out_soc_changed))
    else $error("result changed while stalled");
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken with result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after request");
endmodule

bind battery_soc_coulomb_estimator bsce_checker u_bsce_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_soc(out_soc),
  .out_soc_changed(out_soc_changed)
);
`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the coulomb-counting state-of-charge estimator
module tb_top;
  import bsce_pkg::*;

  localparam int LimitCycles = 3000000;
  localparam int DrainWait = 100;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [19:0] current_ma;
    logic [15:0]        elapsed_ms;
    logic signed [7:0]  percent;
    logic [15:0]        cell_voltage_mv;
    logic [3:0]         point_index;
    logic [15:0]        point_voltage_mv;
    logic [13:0]        point_soc;
  } soc_req_t;

  typedef struct packed {
    logic [13:0] soc;
    logic        changed;
  } soc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CAPACITY;
  logic [19:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = CMD_NONE;
  logic signed [19:0] in_current_ma = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic signed [7:0] in_percent = '0;
  logic [15:0] in_cell_voltage_mv = '0;
  logic [3:0] in_point_index = '0;
  logic [15:0] in_point_voltage_mv = '0;
  logic [13:0] in_point_soc = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SocW-1:0] out_soc;
  logic out_soc_changed;

  battery_soc_coulomb_estimator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_current_ma(in_current_ma),
    .in_elapsed_ms(in_elapsed_ms), .in_percent(in_percent),
    .in_cell_voltage_mv(in_cell_voltage_mv), .in_point_index(in_point_index),
    .in_point_voltage_mv(in_point_voltage_mv), .in_point_soc(in_point_soc),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_soc(out_soc), .out_soc_changed(out_soc_changed)
  );

  always #6 clk = ~clk;

  // predictor state
  longint capacity_mah, charge_limit_mv, discharge_limit_mv;
  longint soc_level, charge_acc;
  longint ocv_pts[16];
  longint soc_pts[16];

  soc_rsp_t expected_soc_q[$];
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit no_idle = 0;

  function automatic longint clamp_soc(input longint s);
    if (s < 0) return 0;
    if (s > 10000) return 10000;
    return s;
  endfunction

  function automatic longint interp_soc(input longint a[16], input longint b[16],
                                        input int n, input longint v);
    bit rising;
    bit hit;
    rising = a[0] < a[n-1];
    for (int i = 0; i < n; i++) begin
      hit = rising ? (v <= a[i]) : (v >= a[i]);
      if (hit) begin
        if (i == 0) return clamp_soc(b[0]);
        if (a[i] == a[i-1]) return clamp_soc(b[i]);
        return clamp_soc(b[i-1] + ((b[i] - b[i-1]) * (v - a[i-1])) / (a[i] - a[i-1]));
      end
    end
    return clamp_soc(b[n-1]);
  endfunction

  function automatic soc_rsp_t predict_soc(input soc_req_t r);
    longint prev, cap, mag, pct;
    bit ocv_zero, soc_zero;
    longint a[16];
    longint b[16];
    soc_rsp_t rsp;
    prev = soc_level;
    case (r.command)
      CMD_TICK: begin
        cap = (capacity_mah == 0) ? 1 : capacity_mah;
        charge_acc += longint'(r.current_ma) * longint'(r.elapsed_ms);
        mag = (charge_acc < 0) ? -charge_acc : charge_acc;
        if (mag > cap * 3600) begin
          soc_level = clamp_soc(soc_level + charge_acc / (cap * 360));
          charge_acc = 0;
        end
      end
      CMD_RESET: begin
        pct = longint'(r.percent);
        ocv_zero = 1;
        soc_zero = 1;
        foreach (ocv_pts[i]) begin
          if (ocv_pts[i] != 0) ocv_zero = 0;
          if (soc_pts[i] != 0) soc_zero = 0;
        end
        if (pct >= 0 && pct <= 100) begin
          soc_level = pct * 100;
        end else if (!ocv_zero && !soc_zero) begin
          soc_level = interp_soc(ocv_pts, soc_pts, 16, longint'(r.cell_voltage_mv));
        end else if (charge_limit_mv == discharge_limit_mv) begin
          soc_level = 0;
        end else begin
          a = '{default: 0};
          b = '{default: 0};
          a[0] = charge_limit_mv;
          a[1] = discharge_limit_mv;
          b[0] = 10000;
          soc_level = interp_soc(a, b, 2, longint'(r.cell_voltage_mv));
        end
      end
      CMD_POINT: begin
        ocv_pts[r.point_index] = longint'(r.point_voltage_mv);
        soc_pts[r.point_index] = longint'(r.point_soc);
      end
      default: ;
    endcase
    rsp.soc = soc_level[13:0];
    rsp.changed = (soc_level != prev);
    return rsp;
  endfunction

  task automatic send_request(input soc_req_t r);
    int gap;
    in_valid <= 1'b1;
    in_command <= r.command;
    in_current_ma <= r.current_ma;
    in_elapsed_ms <= r.elapsed_ms;
    in_percent <= r.percent;
    in_cell_voltage_mv <= r.cell_voltage_mv;
    in_point_index <= r.point_index;
    in_point_voltage_mv <= r.point_voltage_mv;
    in_point_soc <= r.point_soc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_soc_q.push_back(predict_soc(r));
    if (no_idle) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_soc_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CAPACITY:  capacity_mah = longint'(val);
      CFG_CHG_LIMIT: charge_limit_mv = longint'(val[15:0]);
      CFG_DSG_LIMIT: discharge_limit_mv = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  function automatic soc_req_t rand_fields();
    soc_req_t r;
    r.command = CMD_TICK;
    r.current_ma = 20'($urandom());
    r.elapsed_ms = 16'($urandom());
    r.percent = 8'($urandom());
    r.cell_voltage_mv = 16'($urandom());
    r.point_index = 4'($urandom());
    r.point_voltage_mv = 16'($urandom());
    r.point_soc = 14'($urandom());
    return r;
  endfunction

  function automatic soc_req_t mk_tick(input int cur, input int ms);
    soc_req_t r;
    r = rand_fields();
    r.command = CMD_TICK;
    r.current_ma = 20'(cur);
    r.elapsed_ms = 16'(ms);
    return r;
  endfunction

  function automatic soc_req_t mk_reset(input int pct, input int mv);
    soc_req_t r;
    r = rand_fields();
    r.command = CMD_RESET;
    r.percent = 8'(pct);
    r.cell_voltage_mv = 16'(mv);
    return r;
  endfunction

  function automatic soc_req_t mk_point(input int idx, input int mv, input int s);
    soc_req_t r;
    r = rand_fields();
    r.command = CMD_POINT;
    r.point_index = 4'(idx);
    r.point_voltage_mv = 16'(mv);
    r.point_soc = 14'(s);
    return r;
  endfunction

  function automatic soc_req_t rand_request();
    soc_req_t r;
    int pick;
    r = rand_fields();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.command = CMD_TICK;
      case ($urandom_range(0, 3))
        0: ;
        1: r.current_ma = 20'(int'($urandom_range(0, 2000)) - 1000);
        2: r.current_ma = 20'(int'($urandom_range(0, 100000)) - 50000);
        default: r.current_ma = 20'(int'($urandom_range(0, 1000000)) - 500000);
      endcase
      if ($urandom_range(0, 1)) r.elapsed_ms = 16'($urandom_range(0, 2000));
    end else if (pick < 80) begin
      r.command = CMD_RESET;
      if ($urandom_range(0, 2) == 0) r.percent = 8'($urandom_range(0, 100));
      if ($urandom_range(0, 1)) r.cell_voltage_mv = 16'($urandom_range(2000, 4500));
    end else if (pick < 96) begin
      r.command = CMD_POINT;
      if ($urandom_range(0, 1)) r.point_soc = 14'($urandom_range(0, 10000));
    end else begin
      r.command = CMD_NONE;
    end
    return r;
  endfunction

  // table with monotonic voltages, rising or falling; wild_soc gives random soc values
  task automatic load_table(input bit rising, input bit wild_soc);
    int mv, s;
    mv = $urandom_range(2000, 3000);
    for (int i = 0; i < 16; i++) begin
      s = rising ? i * 600 : 10000 - i * 600;
      if (wild_soc) s = $urandom_range(0, 16383);
      send_request(mk_point(i, rising ? mv : 6000 - mv, s));
      mv += $urandom_range(0, 150);
    end
  endtask

  task automatic clear_table();
    for (int i = 0; i < 16; i++) send_request(mk_point(i, 0, 0));
  endtask

  task automatic test_directed();
    send_request(mk_reset(0, 0));
    send_request(mk_reset(100, 0));
    send_request(mk_reset(50, 0));
    send_request(mk_reset(-1, 3650));
    send_request(mk_reset(101, 2500));
    send_request(mk_reset(-128, 0));
    send_request(mk_reset(127, 65535));
    send_request(mk_reset(-5, 3000));
    send_request(mk_tick(500000, 65535));
    send_request(mk_tick(-500000, 65535));
    send_request(mk_tick(-524288, 65535));
    send_request(mk_tick(524287, 0));
    send_request(mk_tick(0, 65535));
    send_request(rand_fields() | soc_req_t'({CMD_NONE, 94'd0}));
    send_request(mk_point(0, 3000, 0));
    send_request(mk_point(15, 4000, 12000));
    send_request(mk_reset(-2, 3999));
    send_request(mk_reset(-2, 4100));
    send_request(mk_reset(-2, 2000));
    send_request(mk_point(0, 0, 0));
    send_request(mk_point(15, 0, 0));
    wait_drained();
    write_reg(CFG_CHG_LIMIT, 20'd3000);
    write_reg(CFG_DSG_LIMIT, 20'd3000);
    write_reg(CFG_UNUSED, 20'hFFFFF);
    send_request(mk_reset(-1, 3000));
    wait_drained();
    write_reg(CFG_CAPACITY, 20'd0);
    send_request(mk_tick(1, 3601));
    send_request(mk_tick(-2000, 2000));
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [19:0] caps[6];
    caps = '{20'd1, 20'd0, 20'd1000000, 20'd50000, 20'd200, 20'hFFFFF};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_CAPACITY, caps[ph]);
      case (ph % 3)
        0: begin
          write_reg(CFG_CHG_LIMIT, 20'd3650);
          write_reg(CFG_DSG_LIMIT, 20'd2500);
        end
        1: begin
          write_reg(CFG_CHG_LIMIT, 20'd0);
          write_reg(CFG_DSG_LIMIT, 20'hFFFF);
        end
        default: begin
          write_reg(CFG_CHG_LIMIT, 20'($urandom()));
          write_reg(CFG_DSG_LIMIT, 20'($urandom()));
        end
      endcase
      no_idle = (ph == 3);
      clear_table();
      for (int k = 0; k < 60; k++) send_request(rand_request());
      load_table(ph[0], ph == 4);
      for (int k = 0; k < 160; k++) send_request(rand_request());
      no_idle = 0;
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    no_idle = 1;
    for (int k = 0; k < 40; k++) send_request(rand_request());
    no_idle = 0;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 20; k++) send_request(rand_request());
    wait_drained();
    for (int k = 0; k < 20; k++) send_request(rand_request());
    wait_drained();
  endtask

  // receiver: changing stall patterns plus one long hold
  int rx_mode = 0;
  int rx_count = 0;
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_count % 4 == 0);
      endcase
    end
  end

  soc_rsp_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_soc_q.size() == 0) begin
        $display("%0t: unexpected request result soc=%0d changed=%0d",
                 $time, out_soc, out_soc_changed);
        errors++;
      end else begin
        want = expected_soc_q.pop_front();
        if (out_soc !== want.soc) begin
          $display("%0t: soc expected %0d actual %0d", $time, want.soc, out_soc);
          errors++;
        end
        if (out_soc_changed !== want.changed) begin
          $display("%0t: soc_changed expected %0d actual %0d",
                   $time, want.changed, out_soc_changed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    capacity_mah = 50000;
    charge_limit_mv = 3650;
    discharge_limit_mv = 2500;
    soc_level = 0;
    charge_acc = 0;
    ocv_pts = '{default: 0};
    soc_pts = '{default: 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
